FILE: rtl/aarm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package aarm_pkg;

  // Pipeline depths.
  localparam int unsigned SQRT_BITS       = 30;
  localparam int unsigned DIV_BITS        = 31;
  localparam int unsigned AX_DLY          = SQRT_BITS + 2;
  localparam int unsigned NORM_LAT        = SQRT_BITS + DIV_BITS + 3;
  localparam int unsigned CORDIC_STEPS    = 28;
  localparam int unsigned CORDIC_CORE_LAT = CORDIC_STEPS + 2;
  localparam int unsigned CORDIC_PAD      = NORM_LAT - CORDIC_CORE_LAT;
  localparam int unsigned MATRIX_LAT      = 4;
  localparam int unsigned TOTAL_LAT       = NORM_LAT + MATRIX_LAT;

  localparam int unsigned OUT_FRAC_BITS_DEF = 16;
  localparam int unsigned OUT_W             = 18;

  localparam logic signed [31:0] ONE_Q30     = 32'sd1073741824;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

  typedef logic signed [OUT_W-1:0] out_t;

  function automatic logic signed [31:0] atan_val(input int unsigned i);
    logic signed [31:0] v;
    case (i)
      0:  v = 32'sd536870912;
      1:  v = 32'sd316933406;
      2:  v = 32'sd167458907;
      3:  v = 32'sd85004756;
      4:  v = 32'sd42667331;
      5:  v = 32'sd21354465;
      6:  v = 32'sd10679838;
      7:  v = 32'sd5340245;
      8:  v = 32'sd2670163;
      9:  v = 32'sd1335087;
      10: v = 32'sd667544;
      11: v = 32'sd333772;
      12: v = 32'sd166886;
      13: v = 32'sd83443;
      14: v = 32'sd41722;
      15: v = 32'sd20861;
      16: v = 32'sd10430;
      17: v = 32'sd5215;
      18: v = 32'sd2608;
      19: v = 32'sd1304;
      20: v = 32'sd652;
      21: v = 32'sd326;
      22: v = 32'sd163;
      23: v = 32'sd81;
      24: v = 32'sd41;
      25: v = 32'sd20;
      26: v = 32'sd10;
      27: v = 32'sd5;
      default: v = 32'sd0;
    endcase
    return v;
  endfunction

  // Q2.30 product rounding: floor((p + 2^29) / 2^30).
  function automatic logic signed [35:0] rnd30(input logic signed [65:0] p);
    logic signed [65:0] s;
    s = (p + 66'sd536870912) >>> 30;
    return s[35:0];
  endfunction

endpackage

`default_nettype wire

FILE: rtl/aarm_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface aarm_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] axis_x;
  logic signed [15:0] axis_y;
  logic signed [15:0] axis_z;
  logic signed [15:0] angle;

  modport source (output valid, axis_x, axis_y, axis_z, angle, input ready);
  modport sink (input valid, axis_x, axis_y, axis_z, angle, output ready);
endinterface

interface aarm_out_if;
  logic              valid;
  logic              ready;
  aarm_pkg::out_t    m00;
  aarm_pkg::out_t    m01;
  aarm_pkg::out_t    m02;
  aarm_pkg::out_t    m10;
  aarm_pkg::out_t    m11;
  aarm_pkg::out_t    m12;
  aarm_pkg::out_t    m20;
  aarm_pkg::out_t    m21;
  aarm_pkg::out_t    m22;
  logic              zero_axis;

  modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22, zero_axis,
                  input ready);
  modport sink (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22, zero_axis,
                output ready);
endinterface

`default_nettype wire

FILE: rtl/axis_angle_to_rotation_matrix_top.sv
// Axis-angle to 3x3 rotation matrix (Rodrigues). One transfer per clock is taken
// while the output is not held off, and each input transfer gives one matrix
// transfer. The latency is set by the 30-stage square root of the
// axis length followed by the 31-stage rounded divide that normalizes the axis;
// the 28-step CORDIC runs beside them. When the output transfer is held off, the
// whole pipeline freezes and the input ready drops with it. A zero axis returns
// the identity with zero_axis set. Entries carry OUT_FRAC_BITS fraction bits and
// saturate to 18 bits.
`timescale 1ns / 1ps
`default_nettype none

module axis_angle_to_rotation_matrix_top #(
  parameter int unsigned OUT_FRAC_BITS = aarm_pkg::OUT_FRAC_BITS_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  aarm_in_if.sink   in_i,
  aarm_out_if.source out_o
);

  localparam int unsigned LAT = aarm_pkg::TOTAL_LAT;

  logic [LAT-1:0] vld_q;
  logic           en;

  assign en       = !vld_q[LAT-1] || out_o.ready;
  assign in_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], in_i.valid};
    end
  end

  logic signed [31:0] ux, uy, uz, cv, sv;
  logic               zero;
  aarm_pkg::out_t     m [9];
  logic               zero_out;

  aarm_norm u_norm (
    .clk_i    (clk_i),
    .en_i     (en),
    .axis_x_i (in_i.axis_x),
    .axis_y_i (in_i.axis_y),
    .axis_z_i (in_i.axis_z),
    .ux_o     (ux),
    .uy_o     (uy),
    .uz_o     (uz),
    .zero_o   (zero)
  );

  aarm_cordic u_cordic (
    .clk_i   (clk_i),
    .en_i    (en),
    .angle_i (in_i.angle),
    .cos_o   (cv),
    .sin_o   (sv)
  );

  aarm_matrix #(
    .OUT_FRAC_BITS (OUT_FRAC_BITS)
  ) u_matrix (
    .clk_i  (clk_i),
    .en_i   (en),
    .ux_i   (ux),
    .uy_i   (uy),
    .uz_i   (uz),
    .cos_i  (cv),
    .sin_i  (sv),
    .zero_i (zero),
    .m_o    (m),
    .zero_o (zero_out)
  );

  assign out_o.valid     = vld_q[LAT-1];
  assign out_o.m00       = m[0];
  assign out_o.m01       = m[1];
  assign out_o.m02       = m[2];
  assign out_o.m10       = m[3];
  assign out_o.m11       = m[4];
  assign out_o.m12       = m[5];
  assign out_o.m20       = m[6];
  assign out_o.m21       = m[7];
  assign out_o.m22       = m[8];
  assign out_o.zero_axis = zero_out;

endmodule

`default_nettype wire

FILE: rtl/aarm_norm.sv
`timescale 1ns / 1ps
`default_nettype none

module aarm_norm (
  input  wire logic               clk_i,
  input  wire logic               en_i,
  input  wire logic signed [15:0] axis_x_i,
  input  wire logic signed [15:0] axis_y_i,
  input  wire logic signed [15:0] axis_z_i,
  output logic signed [31:0]      ux_o,
  output logic signed [31:0]      uy_o,
  output logic signed [31:0]      uz_o,
  output logic                    zero_o
);

  localparam int unsigned SB = aarm_pkg::SQRT_BITS;
  localparam int unsigned DB = aarm_pkg::DIV_BITS;
  localparam int unsigned AD = aarm_pkg::AX_DLY;

  logic        [30:0]      sq_q [3];
  logic        [31:0]      n2_q;
  logic signed [15:0]      ax_q [AD][3];
  logic        [59:0]      srem_q [SB-1];
  logic        [SB-1:0]    root_q [SB];
  logic        [SB-1:0]    len_q [DB];
  logic        [29:0]      drem_q [DB-1][3];
  logic        [30:0]      nlo_q [DB-1][3];
  logic        [DB-1:0]    quo_q [DB][3];
  logic                    neg_q [DB][3];

  logic signed [31:0] sqx, sqy, sqz;
  assign sqx = 32'(axis_x_i) * 32'(axis_x_i);
  assign sqy = 32'(axis_y_i) * 32'(axis_y_i);
  assign sqz = 32'(axis_z_i) * 32'(axis_z_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq_q[0]   <= sqx[30:0];
      sq_q[1]   <= sqy[30:0];
      sq_q[2]   <= sqz[30:0];
      ax_q[0][0] <= axis_x_i;
      ax_q[0][1] <= axis_y_i;
      ax_q[0][2] <= axis_z_i;
      for (int k = 1; k < AD; k++) begin
        ax_q[k] <= ax_q[k-1];
      end
      n2_q <= 32'(sq_q[0]) + 32'(sq_q[1]) + 32'(sq_q[2]);
    end
  end

  // Square root, one result bit per stage, of n2 scaled by 2^28.
  for (genvar s = 0; s < SB; s++) begin : g_sqrt
    localparam int unsigned B = SB - 1 - s;
    logic [59:0]   rem_in;
    logic [SB-1:0] root_in;
    logic [60:0]   cand;
    logic          take;

    if (s == 0) begin : g_first
      assign rem_in  = {n2_q, 28'd0};
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = srem_q[s-1];
      assign root_in = root_q[s-1];
    end

    assign cand = (61'(root_in) << (B + 1)) | (61'd1 << (2 * B));
    assign take = ({1'b0, rem_in} >= cand);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        root_q[s] <= take ? (root_in | (SB'(1) << B)) : root_in;
      end
    end

    if (s < SB - 1) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          srem_q[s] <= take ? (rem_in - cand[59:0]) : rem_in;
        end
      end
    end
  end

  // Rounded division |a| * 2^44 / L, one quotient bit per stage.
  for (genvar d = 0; d < DB; d++) begin : g_div
    localparam int unsigned I = DB - 1 - d;
    logic [SB-1:0] len_in;

    if (d == 0) begin : g_first
      assign len_in = root_q[SB-1];
    end else begin : g_next
      assign len_in = len_q[d-1];
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        len_q[d] <= len_in;
      end
    end

    for (genvar c = 0; c < 3; c++) begin : g_comp
      logic [29:0]   rem_in;
      logic [30:0]   nlo_in;
      logic [DB-1:0] quo_in;
      logic          neg_in;
      logic [30:0]   r2;
      logic          take;

      if (d == 0) begin : g_first
        logic signed [15:0] a;
        logic        [15:0] mag;
        logic        [59:0] num;
        assign a      = ax_q[AD-1][c];
        assign mag    = a[15] ? 16'(-a) : 16'(a);
        assign num    = {mag, 44'd0} + 60'(len_in >> 1);
        assign rem_in = 30'(num[59:31]);
        assign nlo_in = num[30:0];
        assign quo_in = '0;
        assign neg_in = a[15];
      end else begin : g_next
        assign rem_in = drem_q[d-1][c];
        assign nlo_in = nlo_q[d-1][c];
        assign quo_in = quo_q[d-1][c];
        assign neg_in = neg_q[d-1][c];
      end

      assign r2   = {rem_in, nlo_in[I]};
      assign take = (r2 >= {1'b0, len_in});

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          quo_q[d][c] <= take ? (quo_in | (DB'(1) << I)) : quo_in;
          neg_q[d][c] <= neg_in;
        end
      end

      if (d < DB - 1) begin : g_rem
        logic [30:0] diff;
        assign diff = r2 - {1'b0, len_in};
        always_ff @(posedge clk_i) begin
          if (en_i) begin
            drem_q[d][c] <= take ? diff[29:0] : r2[29:0];
            nlo_q[d][c]  <= nlo_in;
          end
        end
      end
    end
  end

  // Clamp to one and restore the sign.
  logic signed [31:0] u_d [3];
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      logic [31:0] qc;
      qc = 32'(quo_q[DB-1][c]);
      if (qc > 32'(aarm_pkg::ONE_Q30)) begin
        qc = 32'(aarm_pkg::ONE_Q30);
      end
      u_d[c] = neg_q[DB-1][c] ? -signed'(qc) : signed'(qc);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ux_o   <= u_d[0];
      uy_o   <= u_d[1];
      uz_o   <= u_d[2];
      zero_o <= (len_q[DB-1] == '0);
    end
  end

endmodule

`default_nettype wire

FILE: rtl/aarm_cordic.sv
`timescale 1ns / 1ps
`default_nettype none

module aarm_cordic (
  input  wire logic               clk_i,
  input  wire logic               en_i,
  input  wire logic signed [15:0] angle_i,
  output logic signed [31:0]      cos_o,
  output logic signed [31:0]      sin_o
);

  localparam int unsigned NS  = aarm_pkg::CORDIC_STEPS;
  localparam int unsigned PAD = aarm_pkg::CORDIC_PAD;

  logic [15:0]        shifted;
  logic signed [31:0] z0_q;
  logic [1:0]         quad_q [NS+1];
  logic signed [33:0] x_q [NS];
  logic signed [33:0] y_q [NS];
  logic signed [31:0] z_q [NS];
  logic signed [31:0] c_q [PAD+1];
  logic signed [31:0] s_q [PAD+1];

  // Fold the angle into a quadrant and a residue of plus or minus 45 degrees.
  assign shifted = angle_i + 16'h2000;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      quad_q[0] <= shifted[15:14];
      z0_q      <= 32'(signed'({~shifted[13], shifted[12:0]})) <<< 16;
      for (int k = 1; k <= NS; k++) begin
        quad_q[k] <= quad_q[k-1];
      end
    end
  end

  for (genvar i = 0; i < NS; i++) begin : g_step
    logic signed [33:0] x_in, y_in, dx, dy;
    logic signed [31:0] z_in, at;

    if (i == 0) begin : g_first
      assign x_in = aarm_pkg::CORDIC_GAIN;
      assign y_in = '0;
      assign z_in = z0_q;
    end else begin : g_next
      assign x_in = x_q[i-1];
      assign y_in = y_q[i-1];
      assign z_in = z_q[i-1];
    end

    assign dx = y_in >>> i;
    assign dy = x_in >>> i;
    assign at = aarm_pkg::atan_val(i);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!z_in[31]) begin
          x_q[i] <= x_in - dx;
          y_q[i] <= y_in + dy;
          z_q[i] <= z_in - at;
        end else begin
          x_q[i] <= x_in + dx;
          y_q[i] <= y_in - dy;
          z_q[i] <= z_in + at;
        end
      end
    end
  end

  logic signed [33:0] cx, cy;
  logic signed [31:0] c_d, s_d;

  always_comb begin
    case (quad_q[NS])
      2'd0: begin
        cx = x_q[NS-1];
        cy = y_q[NS-1];
      end
      2'd1: begin
        cx = -y_q[NS-1];
        cy = x_q[NS-1];
      end
      2'd2: begin
        cx = -x_q[NS-1];
        cy = -y_q[NS-1];
      end
      default: begin
        cx = y_q[NS-1];
        cy = -x_q[NS-1];
      end
    endcase
    if (cx > 34'(aarm_pkg::ONE_Q30)) begin
      c_d = aarm_pkg::ONE_Q30;
    end else if (cx < -34'(aarm_pkg::ONE_Q30)) begin
      c_d = -aarm_pkg::ONE_Q30;
    end else begin
      c_d = cx[31:0];
    end
    if (cy > 34'(aarm_pkg::ONE_Q30)) begin
      s_d = aarm_pkg::ONE_Q30;
    end else if (cy < -34'(aarm_pkg::ONE_Q30)) begin
      s_d = -aarm_pkg::ONE_Q30;
    end else begin
      s_d = cy[31:0];
    end
  end

  // Delay line that lines the angle results up with the normalized axis.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c_q[0] <= c_d;
      s_q[0] <= s_d;
      for (int k = 1; k <= PAD; k++) begin
        c_q[k] <= c_q[k-1];
        s_q[k] <= s_q[k-1];
      end
    end
  end

  assign cos_o = c_q[PAD];
  assign sin_o = s_q[PAD];

endmodule

`default_nettype wire

FILE: rtl/aarm_matrix.sv
`timescale 1ns / 1ps
`default_nettype none

module aarm_matrix #(
  parameter int unsigned OUT_FRAC_BITS = aarm_pkg::OUT_FRAC_BITS_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               en_i,
  input  wire logic signed [31:0] ux_i,
  input  wire logic signed [31:0] uy_i,
  input  wire logic signed [31:0] uz_i,
  input  wire logic signed [31:0] cos_i,
  input  wire logic signed [31:0] sin_i,
  input  wire logic               zero_i,
  output aarm_pkg::out_t          m_o [9],
  output logic                    zero_o
);

  localparam int unsigned SH = 30 - OUT_FRAC_BITS;

  // Stage 1: products of the unit axis and with the sine.
  logic signed [31:0] p1_q [6];
  logic signed [31:0] w1_q [3];
  logic signed [31:0] c1_q;
  logic signed [32:0] t1_q;
  logic               z1_q;

  logic signed [63:0] pr [9];
  always_comb begin
    pr[0] = 64'(ux_i) * 64'(ux_i);
    pr[1] = 64'(uy_i) * 64'(uy_i);
    pr[2] = 64'(uz_i) * 64'(uz_i);
    pr[3] = 64'(ux_i) * 64'(uy_i);
    pr[4] = 64'(ux_i) * 64'(uz_i);
    pr[5] = 64'(uy_i) * 64'(uz_i);
    pr[6] = 64'(uz_i) * 64'(sin_i);
    pr[7] = 64'(uy_i) * 64'(sin_i);
    pr[8] = 64'(ux_i) * 64'(sin_i);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 6; k++) begin
        p1_q[k] <= 32'(aarm_pkg::rnd30(66'(pr[k])));
      end
      for (int k = 0; k < 3; k++) begin
        w1_q[k] <= 32'(aarm_pkg::rnd30(66'(pr[k+6])));
      end
      c1_q <= cos_i;
      t1_q <= 33'(aarm_pkg::ONE_Q30) - 33'(cos_i);
      z1_q <= zero_i;
    end
  end

  // Stage 2: scale by one minus cosine.
  logic signed [32:0] p2_q [6];
  logic signed [31:0] w2_q [3];
  logic signed [31:0] c2_q;
  logic               z2_q;

  logic signed [65:0] pt [6];
  always_comb begin
    for (int k = 0; k < 6; k++) begin
      pt[k] = 66'(p1_q[k]) * 66'(t1_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 6; k++) begin
        p2_q[k] <= 33'(aarm_pkg::rnd30(pt[k]));
      end
      w2_q <= w1_q;
      c2_q <= c1_q;
      z2_q <= z1_q;
    end
  end

  // Stage 3: sums, identity for a zero axis.
  logic signed [34:0] m3_q [9];
  logic               z3_q;
  logic signed [34:0] m_d [9];

  always_comb begin
    m_d[0] = 35'(c2_q) + 35'(p2_q[0]);
    m_d[4] = 35'(c2_q) + 35'(p2_q[1]);
    m_d[8] = 35'(c2_q) + 35'(p2_q[2]);
    m_d[3] = 35'(p2_q[3]) + 35'(w2_q[0]);
    m_d[1] = 35'(p2_q[3]) - 35'(w2_q[0]);
    m_d[6] = 35'(p2_q[4]) - 35'(w2_q[1]);
    m_d[2] = 35'(p2_q[4]) + 35'(w2_q[1]);
    m_d[7] = 35'(p2_q[5]) + 35'(w2_q[2]);
    m_d[5] = 35'(p2_q[5]) - 35'(w2_q[2]);
    if (z2_q) begin
      for (int k = 0; k < 9; k++) begin
        m_d[k] = (k % 4 == 0) ? 35'(aarm_pkg::ONE_Q30) : 35'sd0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m3_q <= m_d;
      z3_q <= z2_q;
    end
  end

  // Stage 4: round to the output format and saturate.
  logic signed [35:0] r [9];
  aarm_pkg::out_t     o_d [9];

  if (SH > 0) begin : g_round
    always_comb begin
      for (int k = 0; k < 9; k++) begin
        r[k] = (36'(m3_q[k]) + (36'sd1 <<< (SH - 1))) >>> SH;
      end
    end
  end else begin : g_noround
    always_comb begin
      for (int k = 0; k < 9; k++) begin
        r[k] = 36'(m3_q[k]);
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 9; k++) begin
      if (r[k] > 36'sd131071) begin
        o_d[k] = 18'sd131071;
      end else if (r[k] < -36'sd131072) begin
        o_d[k] = -18'sd131072;
      end else begin
        o_d[k] = r[k][17:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m_o    <= o_d;
      zero_o <= z3_q;
    end
  end

endmodule

`default_nettype wire

FILE: tb/tb.sv
`timescale 1ns / 1ps
`default_nettype none

module tb;

  localparam int unsigned FRAC = aarm_pkg::OUT_FRAC_BITS_DEF;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] az;
    logic signed [15:0] ang;
  } pose_t;

  typedef struct {
    logic signed [17:0] m[9];
    logic zero;
  } rot_t;

  logic clk_i;
  logic rst_ni;
  aarm_in_if  in_bus();
  aarm_out_if out_bus();

  axis_angle_to_rotation_matrix_top #(.OUT_FRAC_BITS(FRAC)) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_bus.sink),
    .out_o (out_bus.source)
  );

  rot_t rot_expected_q[$];
  int   err_cnt;
  bit   idle_en;
  int   idle_cycles;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic longint floor_sh(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint mul_q30(longint a, longint b);
    return (a * b + (64'sd1 <<< 29)) >>> 30;
  endfunction

  function automatic longint clamp_unit(longint v);
    if (v > 64'sd1073741824) return 64'sd1073741824;
    if (v < -64'sd1073741824) return -64'sd1073741824;
    return v;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res, bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n  -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint norm_comp(longint a, longint unsigned len);
    longint unsigned mag, q;
    mag = (a < 0) ? -a : a;
    q = ((mag << 44) + (len >> 1)) / len;
    if (q > 64'd1073741824) q = 64'd1073741824;
    return (a < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic logic signed [17:0] quantize(longint v);
    longint r;
    r = v;
    if (FRAC < 30) r = (v + (64'sd1 <<< (29 - FRAC))) >>> (30 - FRAC);
    if (r > 131071) r = 131071;
    if (r < -131072) r = -131072;
    return r[17:0];
  endfunction

  function automatic void cordic_sincos(logic [15:0] ang, output longint c, output longint s);
    logic [15:0] sh;
    int q;
    longint x, y, z, dx, dy, cx, cy;
    sh = ang + 16'h2000;
    q  = int'(sh[15:14]);
    x  = longint'(aarm_pkg::CORDIC_GAIN);
    y  = 0;
    z  = (longint'(sh[13:0]) - 8192) * 65536;
    for (int i = 0; i < 28; i++) begin
      dx = floor_sh(y, i);
      dy = floor_sh(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(aarm_pkg::atan_val(i));
      end else begin
        x += dx; y -= dy; z += longint'(aarm_pkg::atan_val(i));
      end
    end
    case (q)
      0: begin cx = x;  cy = y;  end
      1: begin cx = -y; cy = x;  end
      2: begin cx = -x; cy = -y; end
      default: begin cx = y; cy = -x; end
    endcase
    c = clamp_unit(cx);
    s = clamp_unit(cy);
  endfunction

  function automatic rot_t rodrigues(pose_t p);
    rot_t r;
    longint ax, ay, az, x, y, z, c, s, t, pp, w;
    longint m[9];
    longint unsigned n2, len;
    ax = longint'(p.ax); ay = longint'(p.ay); az = longint'(p.az);
    n2 = ax * ax + ay * ay + az * az;
    if (n2 == 0) begin
      for (int k = 0; k < 9; k++) m[k] = (k % 4 == 0) ? 64'sd1073741824 : 64'sd0;
      r.zero = 1'b1;
    end else begin
      len = int_sqrt(n2 << 28);
      x = norm_comp(ax, len); y = norm_comp(ay, len); z = norm_comp(az, len);
      cordic_sincos(p.ang, c, s);
      t = 64'sd1073741824 - c;
      m[0] = c + mul_q30(mul_q30(x, x), t);
      m[4] = c + mul_q30(mul_q30(y, y), t);
      m[8] = c + mul_q30(mul_q30(z, z), t);
      pp = mul_q30(mul_q30(x, y), t); w = mul_q30(z, s);
      m[3] = pp + w; m[1] = pp - w;
      pp = mul_q30(mul_q30(x, z), t); w = mul_q30(y, s);
      m[6] = pp - w; m[2] = pp + w;
      pp = mul_q30(mul_q30(y, z), t); w = mul_q30(x, s);
      m[7] = pp + w; m[5] = pp - w;
      r.zero = 1'b0;
    end
    for (int k = 0; k < 9; k++) r.m[k] = quantize(m[k]);
    return r;
  endfunction

  // Sends one item; holds valid across back-to-back transfers.
  task automatic send_pose(pose_t p);
    int gap;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 19);
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_bus.valid  <= 1'b1;
    in_bus.axis_x <= p.ax;
    in_bus.axis_y <= p.ay;
    in_bus.axis_z <= p.az;
    in_bus.angle  <= p.ang;
    do @(posedge clk_i); while (!in_bus.ready);
    rot_expected_q.push_back(rodrigues(p));
  endtask

  task automatic end_burst();
    in_bus.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic signed [15:0] rand_comp();
    case ($urandom_range(0, 5))
      0: return 16'sh7FFF;
      1: return -16'sh8000;
      2: return 16'($urandom_range(0, 4)) - 16'd2;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic test_directed();
    logic signed [15:0] ext[4];
    ext = '{16'sh7FFF, -16'sh8000, 16'sh0001, 16'sh0000};
    send_pose('{16'sd0, 16'sd0, 16'sd0, 16'sd0});
    send_pose('{16'sd0, 16'sd0, 16'sd0, 16'sh7FFF});
    send_pose('{16'sd0, 16'sd0, 16'sd0, -16'sh8000});
    for (int i = 0; i < 4; i++) begin
      send_pose('{ext[i], 16'sd0, 16'sd0, 16'sh4000});
      send_pose('{16'sd0, ext[i], 16'sd0, -16'sh4000});
      send_pose('{16'sd0, 16'sd0, ext[i], 16'sh2000});
    end
    send_pose('{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh1555});
    send_pose('{-16'sh8000, -16'sh8000, -16'sh8000, 16'sh0000});
    send_pose('{16'sh7FFF, -16'sh8000, 16'sh0001, -16'sh2000});
    send_pose('{16'sd1, 16'sd1, 16'sd1, 16'shFFFF});
    end_burst();
  endtask

  task automatic test_random(int n);
    pose_t p;
    for (int i = 0; i < n; i++) begin
      p.ax = rand_comp();
      p.ay = rand_comp();
      p.az = rand_comp();
      p.ang = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 3) * 16'h4000)
                                          : 16'($urandom);
      send_pose(p);
    end
    end_burst();
  endtask

  task automatic drain();
    while (rot_expected_q.size() != 0) @(posedge clk_i);
    repeat (aarm_pkg::TOTAL_LAT + 10) @(posedge clk_i);
  endtask

  // Random backpressure on the result side.
  initial begin
    out_bus.ready <= 1'b0;
    idle_cycles = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (idle_cycles > 0) begin
        idle_cycles--;
        out_bus.ready <= (idle_cycles == 0);
      end else if (idle_en && $urandom_range(0, 9) == 0) begin
        idle_cycles = $urandom_range(1, 19);
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  // Compares every result transfer against the oldest prediction.
  always @(posedge clk_i) begin
    rot_t e;
    logic signed [17:0] act[9];
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      act = '{out_bus.m00, out_bus.m01, out_bus.m02, out_bus.m10, out_bus.m11,
              out_bus.m12, out_bus.m20, out_bus.m21, out_bus.m22};
      if (rot_expected_q.size() == 0) begin
        $error("unexpected result transfer");
        err_cnt++;
      end else begin
        e = rot_expected_q.pop_front();
        for (int k = 0; k < 9; k++) begin
          if (act[k] !== e.m[k]) begin
            $error("m%0d%0d: expected %0d, got %0d", k / 3, k % 3, e.m[k], act[k]);
            err_cnt++;
          end
        end
        if (out_bus.zero_axis !== e.zero) begin
          $error("zero_axis: expected %0d, got %0d", e.zero, out_bus.zero_axis);
          err_cnt++;
        end
      end
    end
  end

  // Ends the run if nothing moves on either side for too long.
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) quiet = 0;
      else quiet++;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("tb: errors");
        $finish;
      end
    end
  end

  initial begin
    err_cnt = 0;
    idle_en = 1'b1;
    rst_ni = 1'b0;
    in_bus.valid  <= 1'b0;
    in_bus.axis_x <= '0;
    in_bus.axis_y <= '0;
    in_bus.axis_z <= '0;
    in_bus.angle  <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(1400);
    idle_en = 1'b0;
    test_random(330);
    drain();
    if (err_cnt == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: files.f
rtl/aarm_pkg.sv
rtl/aarm_if.sv
rtl/aarm_norm.sv
rtl/aarm_cordic.sv
rtl/aarm_matrix.sv
rtl/axis_angle_to_rotation_matrix_top.sv
tb/tb.sv
